>>> src/es2cd_pkg.sv
package es2cd_pkg;

  // Seconds per day is 2^7 * 675: drop the low seven bits, then divide by 675.
  localparam int unsigned SecShift   = 7;
  localparam int unsigned SecW       = 32;
  localparam int unsigned XW         = SecW - SecShift;   // 25-bit partial quotient
  localparam int unsigned IdxW       = 16;                // day index up to 49710

  localparam int unsigned DayDiv     = 675;
  localparam int unsigned DayRecip   = 25451658;          // floor(2^34 / 675)
  localparam int unsigned DayRecipSh = 34;
  localparam int unsigned DayRecipW  = 25;

  localparam int unsigned QW         = IdxW + 2;          // quarter days
  localparam int unsigned YearQd     = 1461;
  localparam int unsigned YearRecip  = 183734;            // floor(2^28 / 1461)
  localparam int unsigned YearRecipSh = 28;
  localparam int unsigned YearRecipW = 18;
  localparam int unsigned OffW       = 8;                 // years since 1970, up to 136

  localparam int unsigned WkW        = IdxW + 1;
  localparam int unsigned WkDiv      = 7;
  localparam int unsigned WkRecip    = 149796;            // floor(2^20 / 7)
  localparam int unsigned WkRecipSh  = 20;
  localparam int unsigned WkRecipW   = 18;
  localparam int unsigned WkQW       = 13;

  localparam int unsigned EpochYear  = 1970;
  localparam int unsigned DoyW       = 9;

  localparam int unsigned DayW       = 5;
  localparam int unsigned MonW       = 4;
  localparam int unsigned YearW      = 12;
  localparam int unsigned WdW        = 3;
  localparam int unsigned OutW       = DayW + MonW + YearW + WdW;

  localparam int unsigned NumMonths  = 12;

  typedef logic [DoyW-1:0] doy_t;
  typedef logic [MonW-1:0] mon_t;

  // First day of year (from 0) of month m (0-based); the leap day counts from March on.
  function automatic doy_t month_start(input mon_t m, input logic leap);
    doy_t base;
    begin
      case (m)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      month_start = base + ((m >= 4'd2 && leap) ? 9'd1 : 9'd0);
    end
  endfunction

endpackage

>>> src/epoch_seconds_to_calendar_date.sv
// An accepted input passes six register stages, ending in the output register.
// Throughput: one transaction per cycle unless stalled; six register stages advance
// together, so the rate is set by the slowest stage, a 25x25 reciprocal multiply.
// A stalled output holds every stage; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
module epoch_seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [4:0] day_of_month, [8:5] month, [20:9] year,
                                  // [23:21] weekday
);
  import es2cd_pkg::*;

  // Global advance: every stage moves when the output register is free or drained.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: estimate day index = (seconds >> 7) / 675 by reciprocal multiply.
  // The estimate is the true quotient or one below it.
  // ---------------------------------------------------------------------------
  logic [XW-1:0]           x0;
  logic [XW+DayRecipW-1:0] p0;
  assign x0 = in_tdata[SecW-1:SecShift];
  assign p0 = (XW+DayRecipW)'(x0) * (XW+DayRecipW)'(DayRecip);

  logic            v1_r;
  logic [XW-1:0]   x1_r;
  logic [IdxW-1:0] qe1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
    if (en) begin
      x1_r  <= x0;
      qe1_r <= p0[DayRecipSh +: IdxW];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: fix the day index with one remainder compare.
  // ---------------------------------------------------------------------------
  logic [XW:0]     back1;
  logic [XW:0]     r1;
  logic [IdxW-1:0] idx_nxt;
  assign back1   = (XW+1)'(qe1_r) * (XW+1)'(DayDiv);
  assign r1      = (XW+1)'(x1_r) - back1;
  assign idx_nxt = (r1 >= (XW+1)'(DayDiv)) ? qe1_r + 1'b1 : qe1_r;

  logic            v2_r;
  logic [IdxW-1:0] idx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      idx2_r <= idx_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: quarter-day count q = 4*index + 2 (midday) and weekday operand
  // w = index + 3; estimate q / 1461 and w / 7 by reciprocal multiply.
  // ---------------------------------------------------------------------------
  logic [QW-1:0]              q2;
  logic [WkW-1:0]             w2;
  logic [QW+YearRecipW-1:0]   p2y;
  logic [WkW+WkRecipW-1:0]    p2w;
  assign q2  = {idx2_r, 2'b10};
  assign w2  = WkW'(idx2_r) + WkW'(3);
  assign p2y = (QW+YearRecipW)'(q2) * (QW+YearRecipW)'(YearRecip);
  assign p2w = (WkW+WkRecipW)'(w2) * (WkW+WkRecipW)'(WkRecip);

  logic            v3_r;
  logic [QW-1:0]   q3_r;
  logic [WkW-1:0]  w3_r;
  logic [OffW-1:0] offe3_r;
  logic [WkQW-1:0] wke3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      q3_r    <= q2;
      w3_r    <= w2;
      offe3_r <= p2y[YearRecipSh +: OffW];
      wke3_r  <= p2w[WkRecipSh +: WkQW];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: fix year offset and weekday; day of year is the quarter-day
  // remainder over 4.
  // ---------------------------------------------------------------------------
  logic [QW-1:0]   r3y;
  logic [QW-1:0]   r3y_fix;
  logic [OffW-1:0] off_nxt;
  logic [WkW-1:0]  r3w;
  logic [WkW-1:0]  r3w_fix;

  assign r3y     = q3_r - QW'(offe3_r) * QW'(YearQd);
  assign off_nxt = (r3y >= QW'(YearQd)) ? offe3_r + 1'b1 : offe3_r;
  assign r3y_fix = (r3y >= QW'(YearQd)) ? r3y - QW'(YearQd) : r3y;
  assign r3w     = w3_r - WkW'(wke3_r) * WkW'(WkDiv);
  assign r3w_fix = (r3w >= WkW'(WkDiv)) ? r3w - WkW'(WkDiv) : r3w;

  logic             v4_r;
  logic [OffW-1:0]  off4_r;
  doy_t             doy4_r;
  logic [WdW-1:0]   wd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      off4_r <= off_nxt;
      doy4_r <= r3y_fix[2 +: DoyW];
      wd4_r  <= r3w_fix[WdW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: month search. The starts of February to December are compared in parallel;
  // take the last month whose start is not after the day of year, else January.
  // ---------------------------------------------------------------------------
  logic leap4;
  mon_t mon_nxt;
  assign leap4 = (off4_r[1:0] == 2'd2);

  always_comb begin
    mon_nxt = '0;
    for (int m = 1; m < NumMonths; m++) begin
      if (doy4_r >= month_start(MonW'(m), leap4)) begin
        mon_nxt = MonW'(m);
      end
    end
  end

  logic             v5_r;
  mon_t             mon5_r;
  doy_t             doy5_r;
  logic             leap5_r;
  logic [YearW-1:0] year5_r;
  logic [WdW-1:0]   wd5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      mon5_r  <= mon_nxt;
      doy5_r  <= doy4_r;
      leap5_r <= leap4;
      year5_r <= YearW'(off4_r) + YearW'(EpochYear);
      wd5_r   <= wd4_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: day of month and output register.
  // ---------------------------------------------------------------------------
  doy_t           dom_full;
  logic [DayW-1:0] dom_nxt;
  assign dom_full = doy5_r - month_start(mon5_r, leap5_r) + 9'd1;
  assign dom_nxt  = dom_full[DayW-1:0];

  logic              out_valid_r;
  logic [OutW-1:0]   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v5_r;
    end
    if (en) begin
      out_data_r <= {wd5_r, year5_r, mon5_r + 4'd1, dom_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
